FILE: hw/rtl/ttlexp_pkg.sv
// shared types and constants for the token expiry table
// no dependencies; used by ttlexp_ctrl, ttlexp_dpath and ttl_token_expiry_table
package ttlexp_pkg;

    // default sizes
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int IN_KEY_W = 32;
    localparam int TIME_W  = 32;
    localparam int TTL_W   = 31;
    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
    localparam logic [TTL_W-1:0]   TTL_RESET = 31'd1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = 32'hFFFF_FFFF;

    // command codes
    localparam logic [CMD_W-1:0] CMD_GENERATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RENEW    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic idx_clear;
        logic idx_step;
        logic clear_wr;
        logic sweep_rd;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic idx_last;
    } dp_status_t;

endpackage

FILE: hw/rtl/ttlexp_ctrl.sv
// sequencer for the token expiry table: clearing pass, sweep, update, result hand-off
// depends on ttlexp_pkg
module ttlexp_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  ttlexp_pkg::dp_status_t  status,
    output ttlexp_pkg::ctrl_cmd_t   cmd
);
    import ttlexp_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // output register can take a new result
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.idx_step = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture   = 1'b1;
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_DRAIN;
                end
                else
                begin
                    cmd.idx_step = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/ttlexp_dpath.sv
// datapath for the token expiry table: entry memory, sweep evaluation, slot choice,
// lifetime register and result registers; depends on ttlexp_pkg
module ttlexp_dpath #(
    parameter int TABLE_DEPTH = ttlexp_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = ttlexp_pkg::KEY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ttlexp_pkg::TTL_W-1:0]        cfg_wr_data,
    input  logic [ttlexp_pkg::CMD_W-1:0]        command,
    input  logic [ttlexp_pkg::IN_KEY_W-1:0]     token_key,
    input  logic [ttlexp_pkg::TIME_W-1:0]       current_time,
    output logic [ttlexp_pkg::COUNT_W-1:0]      live_count,
    output logic                                table_full,
    input  ttlexp_pkg::ctrl_cmd_t               cmd,
    output ttlexp_pkg::dp_status_t              status
);
    import ttlexp_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int WORD_W = 1 + KEY_BITS + TIME_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // entry memory: {valid, key, expiry}
    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    logic [IDX_W-1:0]    idx_reg;
    logic [TTL_W-1:0]    ttl_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   exp_reg;
    logic [WORD_W-1:0]   rd_data_reg;
    logic                eval_vld_reg;
    logic [IDX_W-1:0]    eval_idx_reg;
    logic                match_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    res_cnt_reg;
    logic                res_full_reg;
    logic [COUNT_W-1:0]  live_count_reg;
    logic                table_full_reg;

    logic                ent_valid;
    logic [KEY_BITS-1:0] ent_key;
    logic [TIME_W-1:0]   ent_exp;
    logic                ent_live;
    logic                ent_expire;
    logic [TIME_W:0]     exp_sum;
    logic                is_gen;
    logic                is_renew;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [COUNT_W-1:0]  cnt_sat;

    assign status.idx_last = (idx_reg == IDX_LAST);

    // entry fields of the word being evaluated
    assign ent_valid  = rd_data_reg[WORD_W-1];
    assign ent_key    = rd_data_reg[TIME_W +: KEY_BITS];
    assign ent_exp    = rd_data_reg[TIME_W-1:0];
    assign ent_live   = ent_valid && (ent_exp > now_reg);
    assign ent_expire = ent_valid && !ent_live;

    assign is_gen   = (cmd_reg == CMD_GENERATE);
    assign is_renew = (cmd_reg == CMD_RENEW);

    // saturating expiry sum
    assign exp_sum = {1'b0, now_reg} + {{(TIME_W + 1 - TTL_W){1'b0}}, ttl_reg};

    // memory write port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        if (cmd.clear_wr)
        begin
            wr_en = 1'b1;
        end
        else if (eval_vld_reg && ent_expire)
        begin
            wr_en   = 1'b1;
            wr_addr = eval_idx_reg;
            wr_data = {1'b0, rd_data_reg[WORD_W-2:0]};
        end
        else if (cmd.update)
        begin
            wr_data = {1'b1, key_reg, exp_reg};
            if (match_found_reg && (is_gen || is_renew))
            begin
                wr_en   = 1'b1;
                wr_addr = match_idx_reg;
            end
            else if (is_gen && free_found_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = free_idx_reg;
            end
        end
    end

    // entry memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.sweep_rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // control state: index, lifetime, sweep pipe, search flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            ttl_reg         <= TTL_RESET;
            eval_vld_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cfg_wr_en)
            begin
                ttl_reg <= cfg_wr_data;
            end
            eval_vld_reg <= cmd.sweep_rd;
            if (cmd.capture)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (eval_vld_reg)
            begin
                if (ent_live && (ent_key == key_reg))
                begin
                    match_found_reg <= 1'b1;
                end
                if (!ent_live)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // payload: captured beat, expiry, slot indexes, counts, results
    always_ff @(posedge clk)
    begin
        eval_idx_reg <= idx_reg;
        exp_reg      <= exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];
        if (cmd.capture)
        begin
            cmd_reg <= command;
            key_reg <= KEY_BITS'(token_key);
            now_reg <= current_time;
            cnt_reg <= '0;
        end
        else if (eval_vld_reg)
        begin
            if (ent_live && (ent_key == key_reg) && !match_found_reg)
            begin
                match_idx_reg <= eval_idx_reg;
            end
            if (!ent_live && !free_found_reg)
            begin
                free_idx_reg <= eval_idx_reg;
            end
            if (ent_live)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.update)
        begin
            res_full_reg <= is_gen && !match_found_reg && !free_found_reg;
            if (is_gen && !match_found_reg && free_found_reg)
            begin
                res_cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                res_cnt_reg <= cnt_reg;
            end
        end
        if (cmd.load_out)
        begin
            live_count_reg <= cnt_sat;
            table_full_reg <= res_full_reg;
        end
    end

    // live count clamps at the field maximum
    assign cnt_sat = (CMP_W'(res_cnt_reg) > CMP_W'(COUNT_MAX)) ? COUNT_MAX
                                                               : COUNT_W'(res_cnt_reg);

    assign live_count = live_count_reg;
    assign table_full = table_full_reg;

endmodule

FILE: hw/rtl/ttl_token_expiry_table.sv
// token expiry table: each input beat runs through capture, a sweep through the entry
// memory at one entry read per cycle, drain, update and result load before out_valid
// rises; a new beat is stalled until the previous item is through, and an item waits
// longer in its result load while the previous result is still held by out_stall
// reset: a clearing pass invalidates every entry, with no input beat taken;
// time_to_live resets to 1; configuration writes are taken at any time
module ttl_token_expiry_table #(
    parameter int TABLE_DEPTH = ttlexp_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = ttlexp_pkg::KEY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ttlexp_pkg::TTL_W-1:0]        cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ttlexp_pkg::CMD_W-1:0]        command,
    input  logic [ttlexp_pkg::IN_KEY_W-1:0]     token_key,
    input  logic [ttlexp_pkg::TIME_W-1:0]       current_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ttlexp_pkg::COUNT_W-1:0]      live_count,
    output logic                                table_full
);
    import ttlexp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    ttlexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // table memory and evaluation
    ttlexp_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .command      (command),
        .token_key    (token_key),
        .current_time (current_time),
        .live_count   (live_count),
        .table_full   (table_full),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
